/* hw/rtl/lpht_pkg.sv */
// Package for the linear-probe hash table: codes, widths, FNV constants.
// No dependencies; used by all lpht modules.
`timescale 1ns / 1ps
package lpht_pkg;
  localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001B3;

  // Depth of the slot memory; the effective slot count saturates to it.
  localparam int MaxSlots = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_ABSENT    = 2'd1,
    ST_EMPTY_KEY = 2'd2,
    ST_NO_ROOM   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  localparam logic CfgSlots = 1'b0;
  localparam logic CfgFill  = 1'b1;

  // Handshake from the hash unit to the controller.
  typedef struct packed {
    logic        done;
    logic [63:0] hash;
  } hash_res_t;
endpackage

/* hw/rtl/lpht_hash.sv */
// FNV-1a 64 over up to eight key bytes, one byte per cycle.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
module lpht_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         key_i,
  input  logic [3:0]          len_i,
  output lpht_pkg::hash_res_t res_o
);
  import lpht_pkg::*;

  logic [63:0] h_q, h_d, key_q, mixed;
  logic [3:0]  left_q;
  logic        busy_q, done_q;

  // Multiply by the prime: it is 2^40 + 0x1B3, so a shift-add suffices.
  assign mixed = h_q ^ {56'd0, key_q[7:0]};
  assign h_d   = (mixed << 40) + (mixed * 64'h1B3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      left_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        left_q <= len_i;
      end else if (busy_q) begin
        if (left_q == 4'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        left_q <= left_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q   <= FnvBasis;
      key_q <= key_i;
    end else if (busy_q) begin
      h_q   <= h_d;
      key_q <= key_q >> 8;
    end
  end

  assign res_o.done = done_q;
  assign res_o.hash = h_q;
endmodule

/* hw/rtl/linear_probe_hash_table_unit.sv */
// Top level of the linear-probe hash table. Depends on lpht_pkg, lpht_hash.
// An accepted item hashes its L key bytes, reduces the hash modulo the slot count,
//   then reads and compares the probed slots, goes through a write step on a hit or an
//   insert, and answers; a rejected or trivially answered item goes straight to the answer.
// One item at a time: busy stays high until the result cycle. Reset clears control
//   state, then a clearing pass writes every slot empty with busy high. Results show
//   one cycle; no stall.
`timescale 1ns / 1ps
module linear_probe_hash_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] key_bytes_i,
  input  logic [3:0]  key_length_i,
  input  logic [63:0] new_value_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [63:0] found_value_o,
  output logic        was_update_o
);
  import lpht_pkg::*;

  localparam int IW = $clog2(MaxSlots);
  localparam int CW = $clog2(MaxSlots + 1);
  localparam int WW = 2 + 64 + 64 + 4 + 64;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MOD, S_READ, S_CMP, S_WRITE, S_OUT
  } state_e;

  // Slot store: one word per slot holds mark, hash, key, length and value.
  logic [WW-1:0] mem [MaxSlots];
  logic [WW-1:0] rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_addr;
  logic [WW-1:0] mem_wdata;

  logic [6:0]  slots_q, fill_q;
  state_e      state_q;
  logic [1:0]  op_q;
  logic [63:0] key_q, val_q, hash_q, rem_q;
  logic [3:0]  len_q;
  logic [IW-1:0] idx_q, tomb_q, free_q;
  logic        tomb_v_q, hit_q, free_tomb_q;
  logic [CW-1:0] seen_q, nslots, live_q, dead_q;
  logic [1:0]  st_q;
  logic [63:0] fv_q;
  logic        upd_q, rv_q;
  logic [6:0]  mod_step_q;

  hash_res_t   hres;
  logic        hstart;
  logic [3:0]  len_sat;
  logic [63:0] key_m;

  always_comb begin
    len_sat = (key_length_i > 4'd8) ? 4'd8 : key_length_i;
    key_m = '0;
    for (int b = 0; b < 8; b++)
      if (4'(b) < len_sat) key_m[8*b +: 8] = key_bytes_i[8*b +: 8];
  end

  // Saturate the slot count into 1..MaxSlots.
  always_comb begin
    if (slots_q == 7'd0) nslots = CW'(1);
    else if ({25'd0, slots_q} > MaxSlots) nslots = CW'(MaxSlots);
    else nslots = CW'(slots_q);
  end

  assign hstart = (state_q == S_IDLE) && start && len_sat != 4'd0 &&
                  opcode_i != OP_NOP &&
                  !(opcode_i == OP_INSERT &&
                    ({25'd0, live_q} + {25'd0, dead_q} + 32'd1 > {25'd0, fill_q}));

  lpht_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hstart),
    .key_i  (key_m),
    .len_i  (len_sat),
    .res_o  (hres)
  );

  assign busy = (state_q != S_IDLE);

  // Memory: one write and one read per cycle at the same address, read data registered.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_q <= mem[mem_addr];
  end

  logic [1:0]  rd_mark;
  logic [63:0] rd_hash, rd_key;
  logic [3:0]  rd_len;
  logic [63:0] rd_val;
  assign {rd_mark, rd_hash, rd_key, rd_len, rd_val} = rd_q;
  logic match;
  assign match = rd_mark == MARK_LIVE && rd_hash == hash_q &&
                 rd_len == len_q && rd_key == key_q;

  logic [IW-1:0] idx_nx;
  assign idx_nx = ({1'b0, idx_q} + 1'b1 >= (IW+1)'(nslots)) ? '0 : idx_q + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx_q;
    mem_wdata = {MARK_EMPTY, 196'd0};
    case (state_q)
      S_CLEAR: mem_we = 1'b1;
      S_WRITE: begin
        if (op_q == OP_INSERT) begin
          mem_we    = 1'b1;
          mem_addr  = hit_q ? idx_q : free_q;
          mem_wdata = {MARK_LIVE, hash_q, key_q, len_q, val_q};
        end else if (op_q == OP_REMOVE) begin
          mem_we    = 1'b1;
          mem_wdata = {MARK_TOMB, 196'd0};
        end
      end
      default: ;
    endcase
  end

  // Remainder: restoring subtraction of nslots shifted, one bit per cycle.
  logic [70:0] div_sub;
  assign div_sub = {7'd0, rem_q} - ({64'd0, 7'(nslots)} << mod_step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      idx_q    <= '0;
      slots_q  <= 7'd64;
      fill_q   <= 7'd48;
      live_q   <= '0;
      dead_q   <= '0;
      rv_q     <= 1'b0;
    end else begin
      rv_q <= (state_q == S_OUT);
      if (cfg_we_i) begin
        if (cfg_index_i == CfgSlots) slots_q <= cfg_data_i;
        else fill_q <= cfg_data_i;
      end
      case (state_q)
        // Walk every slot once after reset and mark it empty.
        S_CLEAR: begin
          if (idx_q == IW'(MaxSlots - 1)) state_q <= S_IDLE;
          idx_q <= idx_q + 1'b1;
        end
        S_IDLE: if (start) begin
          op_q <= opcode_i; key_q <= key_m; len_q <= len_sat;
          val_q <= new_value_i; fv_q <= '0; upd_q <= 1'b0;
          if (len_sat == 4'd0) begin
            st_q <= ST_EMPTY_KEY; state_q <= S_OUT;
          end else if (opcode_i == OP_NOP) begin
            st_q <= ST_ABSENT; state_q <= S_OUT;
          end else if (!hstart) begin
            st_q <= ST_NO_ROOM; state_q <= S_OUT;
          end else begin
            st_q <= ST_DONE; state_q <= S_HASH;
          end
        end
        S_HASH: if (hres.done) begin
          hash_q <= hres.hash; rem_q <= hres.hash;
          mod_step_q <= 7'd63; state_q <= S_MOD;
        end
        S_MOD: begin
          // Skip shifts that lose bits of the divisor.
          if (!div_sub[70] && (({64'd0, 7'(nslots)} << mod_step_q) >> mod_step_q)
              == {64'd0, 7'(nslots)})
            rem_q <= div_sub[63:0];
          if (mod_step_q == 7'd0) begin
            state_q <= S_READ; seen_q <= '0; tomb_v_q <= 1'b0;
          end
          mod_step_q <= mod_step_q - 7'd1;
        end
        S_READ: begin
          if (mod_step_q == 7'h7F) idx_q <= IW'(rem_q);
          mod_step_q <= '0;
          state_q <= (mod_step_q == 7'h7F) ? S_READ : S_CMP;
        end
        S_CMP: begin
          hit_q <= match;
          if (rd_mark == MARK_EMPTY) begin
            free_q <= tomb_v_q ? tomb_q : idx_q;
            free_tomb_q <= tomb_v_q;
            if (op_q == OP_INSERT) state_q <= S_WRITE;
            else begin st_q <= ST_ABSENT; state_q <= S_OUT; end
          end else if (match) begin
            state_q <= S_WRITE;
          end else begin
            if (rd_mark == MARK_TOMB && !tomb_v_q) begin
              tomb_v_q <= 1'b1; tomb_q <= idx_q;
            end
            if (seen_q + 1'b1 >= nslots) begin
              if (op_q != OP_INSERT) begin st_q <= ST_ABSENT; state_q <= S_OUT; end
              else if (tomb_v_q || rd_mark == MARK_TOMB) begin
                free_q <= tomb_v_q ? tomb_q : idx_q;
                free_tomb_q <= 1'b1;
                state_q <= S_WRITE;
              end else begin st_q <= ST_NO_ROOM; state_q <= S_OUT; end
            end else begin
              seen_q <= seen_q + 1'b1; idx_q <= idx_nx; state_q <= S_READ;
            end
          end
        end
        S_WRITE: begin
          state_q <= S_OUT;
          if (op_q == OP_INSERT) begin
            if (hit_q) upd_q <= 1'b1;
            else begin
              if (free_tomb_q && dead_q != '0) dead_q <= dead_q - 1'b1;
              live_q <= live_q + 1'b1;
            end
          end else if (op_q == OP_FIND) fv_q <= rd_val;
          else begin
            if (live_q != '0) live_q <= live_q - 1'b1;
            dead_q <= dead_q + 1'b1;
          end
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = rv_q;
  assign status_o       = st_q;
  assign found_value_o  = fv_q;
  assign was_update_o   = upd_q;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("double result");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy) else $error("busy after result");
  a_update_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && was_update_o) |-> status_o == ST_DONE) else $error("bad update");
endmodule

/* tb/sv/linear_probe_hash_table_unit_tb.sv */
// Testbench for linear_probe_hash_table_unit: directed and random table requests.
// Depends on lpht_pkg and the unit; a built-in table model predicts every result.
`timescale 1ns / 1ps
module linear_probe_hash_table_unit_tb;
  import lpht_pkg::*;

  // One predicted response of the table.
  typedef struct {
    status_e     status;
    logic [63:0] value;
    logic        upd;
  } answer_t;

  // Table mirror plus the queue of answers still to come.
  class table_scoreboard;
    mark_e       mark[64];
    logic [63:0] hsh[64];
    logic [63:0] key[64];
    logic [3:0]  klen[64];
    logic [63:0] val[64];
    int          live;
    int          tombs;
    int          slots;
    int          fill;
    answer_t     pending[$];
    int          errors;

    function void clear();
      foreach (mark[i]) mark[i] = MARK_EMPTY;
      live = 0;
      tombs = 0;
      slots = 64;
      fill = 48;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [6:0] d);
      if (idx == CfgSlots) slots = (d == 0) ? 1 : (d > 64) ? 64 : d;
      else fill = d;
    endfunction

    function logic [63:0] fnv(logic [63:0] k, int n);
      logic [63:0] h;
      h = 64'hCBF29CE484222325;
      for (int i = 0; i < n; i++) begin
        h = h ^ {56'd0, k[8*i +: 8]};
        h = h * 64'h00000100000001B3;
      end
      return h;
    endfunction

    // Note an accepted item: apply it to the mirror and queue its answer.
    function void note_item(op_e op, logic [63:0] kb, logic [3:0] kl, logic [63:0] nv);
      answer_t a;
      int n, idx, tomb, hit, free_at;
      logic [63:0] k, h;
      a.status = ST_DONE;
      a.value = 0;
      a.upd = 0;
      n = (kl > 8) ? 8 : kl;
      k = kb;
      if (n < 8) k = kb & ((64'd1 << (8 * n)) - 1);
      if (n == 0) a.status = ST_EMPTY_KEY;
      else if (op == OP_NOP) a.status = ST_ABSENT;
      else if (op == OP_INSERT && live + tombs + 1 > fill) a.status = ST_NO_ROOM;
      else begin
        h = fnv(k, n);
        idx = int'(h % slots);
        tomb = -1;
        hit = -1;
        free_at = -1;
        for (int s = 0; s < slots; s++) begin
          if (mark[idx] == MARK_EMPTY) begin
            free_at = (tomb >= 0) ? tomb : idx;
            break;
          end
          if (mark[idx] == MARK_LIVE && hsh[idx] == h && klen[idx] == n && key[idx] == k) begin
            hit = idx;
            break;
          end
          if (mark[idx] == MARK_TOMB && tomb < 0) tomb = idx;
          idx = (idx + 1) % slots;
          if (s == slots - 1) free_at = tomb;
        end
        if (op == OP_INSERT) begin
          if (hit >= 0) begin
            val[hit] = nv;
            a.upd = 1;
          end else if (free_at < 0) a.status = ST_NO_ROOM;
          else begin
            if (mark[free_at] == MARK_TOMB && tombs > 0) tombs--;
            mark[free_at] = MARK_LIVE;
            hsh[free_at] = h;
            key[free_at] = k;
            klen[free_at] = 4'(n);
            val[free_at] = nv;
            live++;
          end
        end else if (hit < 0) a.status = ST_ABSENT;
        else if (op == OP_FIND) a.value = val[hit];
        else begin
          mark[hit] = MARK_TOMB;
          if (live > 0) live--;
          tombs++;
        end
      end
      pending.push_back(a);
    endfunction

    function void check_result(logic [1:0] st, logic [63:0] fv, logic wu);
      answer_t a;
      if (pending.size() == 0) begin
        $error("unexpected result: status %0d", st);
        errors++;
        return;
      end
      a = pending.pop_front();
      if (st !== a.status) begin
        $error("status: expected %0d, actual %0d", a.status, st);
        errors++;
      end
      if (fv !== a.value) begin
        $error("found_value: expected %h, actual %h", a.value, fv);
        errors++;
      end
      if (wu !== a.upd) begin
        $error("was_update: expected %0d, actual %0d", a.upd, wu);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_index_i = 0;
  logic [6:0]  cfg_data_i = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  opcode_i = 0;
  logic [63:0] key_bytes_i = 0;
  logic [3:0]  key_length_i = 0;
  logic [63:0] new_value_i = 0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [63:0] found_value_o;
  logic        was_update_o;

  linear_probe_hash_table_unit uut (.*);

  table_scoreboard sb = new();
  // Small pool of keys so inserts, finds and removes hit each other often.
  logic [63:0] key_pool[16];
  logic [3:0]  len_pool[16];
  int          burst_left = 0;

  initial forever #4 clk_i = ~clk_i;

  // Sample results at each edge; the receiver cannot stall, so just check.
  always @(posedge clk_i)
    if (rst_ni && result_valid_o) sb.check_result(status_o, found_value_o, was_update_o);

  // Present one item and hold it until the unit takes it.
  task automatic send_item(op_e op, logic [63:0] kb, logic [3:0] kl, logic [63:0] nv);
    // Sender idles in bursts: after a burst, drop start for a random gap.
    if (burst_left == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1;
    opcode_i <= op;
    key_bytes_i <= kb;
    key_length_i <= kl;
    new_value_i <= nv;
    do @(posedge clk_i); while (busy);
    sb.note_item(op, kb, kl, nv);
  endtask

  // Wait until every answer is in, then let the unit settle before a write.
  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [6:0] d);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
    cfg_we_i <= 0;
  endtask

  task automatic random_item();
    int p;
    op_e op;
    logic [63:0] kb;
    logic [3:0] kl;
    p = $urandom_range(0, 15);
    op = op_e'($urandom_range(0, 9) < 4 ? 0 : $urandom_range(0, 9) < 6 ? 1 :
                $urandom_range(0, 3) == 0 ? 3 : 2);
    kb = key_pool[p];
    kl = len_pool[p];
    if ($urandom_range(0, 9) == 0) begin
      kb = {$urandom, $urandom};
      kl = 4'($urandom_range(0, 15));
    end else if ($urandom_range(0, 4) == 0) begin
      // Garbage past the key length must be ignored.
      kb = kb | ({$urandom, $urandom} << (8 * ((kl > 8) ? 8 : kl)));
    end
    send_item(op, kb, kl, {$urandom, $urandom});
  endtask

  initial begin
    sb.clear();
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      len_pool[i] = 4'($urandom_range(1, 9));
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, every opcode, empty key, long length, opcode three.
    send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 0);
    send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h1234);
    send_item(OP_INSERT, 64'h0, 4'd1, 64'h0);
    send_item(OP_FIND, 64'hFF00, 4'd1, 0);
    send_item(OP_INSERT, 64'hAB, 4'd0, 64'h5);
    send_item(OP_FIND, 64'hAB, 4'd0, 0);
    send_item(OP_REMOVE, 64'hAB, 4'd0, 0);
    send_item(OP_NOP, 64'hAB, 4'd3, 0);
    send_item(OP_NOP, 64'hAB, 4'd0, 0);
    send_item(OP_REMOVE, 64'h0, 4'd1, 0);
    send_item(OP_REMOVE, 64'h0, 4'd1, 0);
    send_item(OP_FIND, 64'h0, 4'd1, 0);
    send_item(OP_INSERT, 64'h0, 4'd1, 64'h77);
    send_item(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 0);
    drain();

    // Tiny table: one slot, then a full probe with no free slot.
    write_reg(CfgSlots, 7'd1);
    write_reg(CfgFill, 7'd64);
    send_item(OP_INSERT, 64'h11, 4'd1, 64'h1);
    send_item(OP_INSERT, 64'h22, 4'd1, 64'h2);
    send_item(OP_FIND, 64'h22, 4'd1, 0);
    drain();
    // Fill limit of one with entries already counted, then slot count zero.
    write_reg(CfgFill, 7'd1);
    send_item(OP_INSERT, 64'h33, 4'd1, 64'h3);
    drain();
    write_reg(CfgSlots, 7'd0);
    drain();
    write_reg(CfgSlots, 7'd127);
    send_item(OP_INSERT, 64'h11, 4'd1, 64'h9);
    drain();

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CfgSlots, 7'd64); write_reg(CfgFill, 7'd127); end
        1: begin write_reg(CfgSlots, 7'd8); write_reg(CfgFill, 7'd100); end
        2: begin write_reg(CfgSlots, 7'd3); write_reg(CfgFill, 7'd64); end
        3: begin write_reg(CfgSlots, 7'($urandom_range(1, 64))); write_reg(CfgFill, 7'd48); end
        4: begin write_reg(CfgSlots, 7'd64); write_reg(CfgFill, 7'($urandom_range(1, 64))); end
        default: begin write_reg(CfgSlots, 7'd16); write_reg(CfgFill, 7'd12); end
      endcase
      for (int i = 0; i < 120; i++) random_item();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_hash.sv
hw/rtl/linear_probe_hash_table_unit.sv
tb/sv/linear_probe_hash_table_unit_tb.sv
